FILE: src/bmp24_pixel_stream_decoder_unit_defines.svh
// Assertion macros shared by the checker of the pixel stream decoder.
`ifndef BMP24_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH
`define BMP24_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH

// Overlapping implication, switched off while reset is high.
`define BMP24_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmp24 assertion failed");

// Implication on the next cycle, switched off while reset is high.
`define BMP24_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmp24 assertion failed");

// Implication on the next cycle that is also checked out of reset.
`define BMP24_ASSERT_RESET(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("bmp24 reset assertion failed");

`endif

FILE: src/bmp24_pkg.sv
package bmp24_pkg;

   localparam logic [5:0] PIXEL_START = 6'd54;
   localparam logic [5:0] WIDTH_AT    = 6'd18;
   localparam logic [5:0] HEIGHT_AT   = 6'd22;
   localparam int         DIM_BYTES   = 4;

   typedef enum logic [2:0] {
      PH_BLUE  = 3'b001,
      PH_GREEN = 3'b010,
      PH_RED   = 3'b100
   } phase_type;

   typedef struct packed {
      logic       start_of_file;
      logic [7:0] data_byte;
   } byte_beat_type;

   typedef struct packed {
      logic        last_pixel;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [11:0] pixel_y;
      logic [11:0] pixel_x;
   } pixel_type;

endpackage

FILE: src/bmp24_ingress.sv
module bmp24_ingress import bmp24_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          beat_valid,
   output logic          beat_ready,
   input  byte_beat_type beat_in,
   input  logic          step,
   output logic          held,
   output byte_beat_type beat_out
);

   logic          held_ff;
   logic          held_in;
   byte_beat_type beat_ff;
   logic          take;

   assign beat_ready = !held_ff || step;
   assign take       = beat_valid && beat_ready;

   always_comb begin
      held_in = held_ff;
      if (take) begin
         held_in = 1'b1;
      end else if (step) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff <= beat_in;
      end
   end

   assign held     = held_ff;
   assign beat_out = beat_ff;

endmodule

FILE: src/bmp24_parser.sv
module bmp24_parser import bmp24_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  byte_beat_type beat,
   output logic          emit,
   output pixel_type     pixel
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic [5:0]    hoff_ff, hoff_in, hoff_cur;
   logic [31:0]   width_ff, width_in;
   logic [31:0]   height_ff, height_in;
   logic [CW-1:0] column_ff, column_in, column_plus;
   logic [RW-1:0] row_ff, row_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    blue_ff, blue_in;
   logic [7:0]    green_ff, green_in;
   logic [1:0]    pad_ff, pad_in;
   logic          finished_ff, finished_in;
   logic          width_ok, height_ok, dims_ok;
   logic          emit_raw;
   logic [31:0]   col_ext, row_ext;

   assign width_ok  = !width_ff[31] && (width_ff != 32'd0) && (width_ff <= 32'(MAX_WIDTH));
   assign height_ok = !height_ff[31] && (height_ff != 32'd0)
                      && (height_ff <= 32'(MAX_HEIGHT));
   assign dims_ok   = width_ok && height_ok;

   assign hoff_cur    = beat.start_of_file ? 6'd0 : hoff_ff;
   assign column_plus = column_ff + CW'(1);
   assign col_ext     = 32'(column_ff);
   assign row_ext     = 32'(row_ff);

   always_comb begin
      hoff_in     = hoff_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      pad_in      = pad_ff;
      finished_in = finished_ff;
      emit_raw    = 1'b0;
      if (hoff_cur < PIXEL_START) begin
         for (int i = 0; i < DIM_BYTES; i++) begin
            if (hoff_cur == WIDTH_AT + 6'(i)) begin
               width_in[8*i +: 8] = beat.data_byte;
            end
            if (hoff_cur == HEIGHT_AT + 6'(i)) begin
               height_in[8*i +: 8] = beat.data_byte;
            end
         end
         hoff_in = hoff_cur + 6'd1;
         if (hoff_cur == PIXEL_START - 6'd1) begin
            column_in   = '0;
            row_in      = dims_ok ? height_ff[RW-1:0] - RW'(1) : '0;
            phase_in    = PH_BLUE;
            pad_in      = 2'd0;
            finished_in = !dims_ok;
         end
      end else if (!finished_ff) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else begin
            unique case (phase_ff)
               PH_BLUE: begin
                  blue_in  = beat.data_byte;
                  phase_in = PH_GREEN;
               end
               PH_GREEN: begin
                  green_in = beat.data_byte;
                  phase_in = PH_RED;
               end
               PH_RED: begin
                  emit_raw  = 1'b1;
                  phase_in  = PH_BLUE;
                  column_in = column_plus;
                  if (column_plus == width_ff[CW-1:0]) begin
                     column_in = '0;
                     if (row_ff == '0) begin
                        finished_in = 1'b1;
                     end else begin
                        row_in = row_ff - RW'(1);
                        pad_in = width_ff[1:0];
                     end
                  end
               end
               default: begin
                  phase_in = PH_BLUE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hoff_ff     <= 6'd0;
         phase_ff    <= PH_BLUE;
         pad_ff      <= 2'd0;
         finished_ff <= 1'b0;
      end else if (step) begin
         hoff_ff     <= hoff_in;
         phase_ff    <= phase_in;
         pad_ff      <= pad_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
      end
   end

   assign emit             = step && emit_raw;
   assign pixel.pixel_x    = col_ext[11:0];
   assign pixel.pixel_y    = row_ext[11:0];
   assign pixel.red        = beat.data_byte;
   assign pixel.green      = green_ff;
   assign pixel.blue       = blue_ff;
   assign pixel.last_pixel = (column_plus == width_ff[CW-1:0]) && (row_ff == '0);

endmodule

FILE: src/bmp24_egress.sv
module bmp24_egress import bmp24_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  pixel_type pixel_in,
   output logic      space,
   output logic      out_valid,
   input  logic      out_ready,
   output pixel_type pixel_out
);

   logic      valid_ff;
   logic      valid_in;
   pixel_type pixel_ff;

   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign pixel_out = pixel_ff;

endmodule

FILE: src/bmp24_pixel_stream_decoder_unit.sv
// A taken byte waits in the ingress register; a red byte loads the rsp pixel beat.
// Throughput: one byte per cycle, held only while the result register is full
// and the sink is not ready.
// Reset is synchronous and active high; afterwards the next byte is taken as offset 0.
// Header parsing restarts whenever req_tuser marks the start of a file.
module bmp24_pixel_stream_decoder_unit import bmp24_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tuser,  // start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // pixel_x, pixel_y, red, green, blue
   output logic        rsp_tlast   // last_pixel
);

   byte_beat_type beat_in, beat_held;
   pixel_type     pixel_next, pixel_out;
   logic          held, space, step, emit;

   assign beat_in.data_byte     = req_tdata;
   assign beat_in.start_of_file = req_tuser;
   assign step                  = held && space;

   bmp24_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_tvalid),
      .beat_ready (req_tready),
      .beat_in    (beat_in),
      .step       (step),
      .held       (held),
      .beat_out   (beat_held)
   );

   bmp24_parser #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .beat  (beat_held),
      .emit  (emit),
      .pixel (pixel_next)
   );

   bmp24_egress u_egress (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .pixel_in  (pixel_next),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .pixel_out (pixel_out)
   );

   assign rsp_tdata = {pixel_out.blue, pixel_out.green, pixel_out.red,
                       pixel_out.pixel_y, pixel_out.pixel_x};
   assign rsp_tlast = pixel_out.last_pixel;

endmodule

FILE: src/bmp24_checker.sv
`include "bmp24_pixel_stream_decoder_unit_defines.svh"

module bmp24_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   `BMP24_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   `BMP24_ASSERT_NOW(a_new_beat_has_source, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2))

   `BMP24_ASSERT_NOW(a_last_on_top_row, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[23:12] == 12'd0)

   `BMP24_ASSERT_RESET(a_reset_clears, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind bmp24_pixel_stream_decoder_unit bmp24_checker u_checker (.*);
